// File: hdl/prqs_pkg.sv
// prqs_pkg: constants, codes and types shared by the ready-queue scheduler files
package prqs_pkg;

  // table sizes
  localparam int THREADS = 8;
  localparam int LEVELS  = 16;

  // payload field widths
  localparam int ACTION_W = 3;
  localparam int TID_W    = 3;
  localparam int PREQ_W   = 5;
  localparam int STATUS_W = 2;
  localparam int PRIO_W   = 4;

  // link, head and tail codes
  localparam int CODE_W = 4;
  localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(15);

  // index widths
  localparam int TIX_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // highest priority that can be stored
  localparam int TOP_PRIORITY = (LEVELS - 1 < 15) ? LEVELS - 1 : 15;

  typedef logic [TIX_W-1:0] tix_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [PRIO_W-1:0] prio_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE   = 3'd0,
    ACT_READY    = 3'd1,
    ACT_UNREADY  = 3'd2,
    ACT_SCHEDULE = 3'd3,
    ACT_CHANGE   = 3'd4,
    ACT_EXIT     = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ALREADY  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_NO_READY = 2'd3
  } status_t;

endpackage

// File: hdl/prqs_in_if.sv
// prqs_in_if: request channel carrying one scheduler action per transfer
interface prqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [prqs_pkg::ACTION_W-1:0]       action;
  logic [prqs_pkg::TID_W-1:0]          thread_id;
  logic signed [prqs_pkg::PREQ_W-1:0]  priority_req;

  modport source (output valid, output action, output thread_id, output priority_req,
                  input ready);
  modport sink (input valid, input action, input thread_id, input priority_req,
                output ready);
endinterface

// File: hdl/prqs_out_if.sv
// prqs_out_if: result channel carrying one scheduler response per transfer
interface prqs_out_if;
  logic                          valid;
  logic                          ready;
  logic [prqs_pkg::STATUS_W-1:0] status;
  logic [prqs_pkg::TID_W-1:0]    thread_out;
  logic [prqs_pkg::PRIO_W-1:0]   old_priority;

  modport source (output valid, output status, output thread_out, output old_priority,
                  input ready);
  modport sink (input valid, input status, input thread_out, input old_priority,
                output ready);
endinterface

// File: hdl/priority_ready_queue_scheduler_unit.sv
// priority_ready_queue_scheduler_unit: thread table with per-level FIFO ready queues
//
//   channel   direction  payload
//   in_chan   sink       action, thread_id, priority_req
//   out_chan  source     status, thread_out, old_priority
//
// One request at a time walks a small sequencer around one shared link-compare unit.
// Create probes the slots in turn for a free one, up to THREADS of them; schedule
// probes the level heads in turn, up to LEVELS of them.
// The slot scan and the level scan each test one entry per cycle.
// rst_n (synchronous) empties every queue and frees every slot.
// in_chan.ready is high only while no request is in flight; a stalled result holds
// the sequencer in its final step until out_chan takes it.
module priority_ready_queue_scheduler_unit (
  input logic       clk,
  input logic       rst_n,
  prqs_in_if.sink   in_chan,
  prqs_out_if.source out_chan
);
  import prqs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_FREE,
    S_ENQ_LVL,
    S_ENQ_TAIL,
    S_ENQ_LINK,
    S_POP_LVL,
    S_POP_HEAD,
    S_POP_NEXT,
    S_SCAN_LVL,
    S_CHANGE,
    S_DONE
  } state_t;

  state_t state_r;

  // request registers
  logic [TID_W-1:0] tid_r;
  logic             pneg_r;
  prio_t            pclamp_r;

  // sequencer working registers
  tix_t t_r;
  tix_t tl_r;
  tix_t h_r;
  lvl_t lv_r;
  tix_t scan_t_r;
  lvl_t scan_l_r;

  // pending result
  status_t          res_status_r;
  logic [TID_W-1:0] res_tout_r;
  prio_t            res_old_r;

  // output register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [TID_W-1:0] out_tout_r;
  prio_t            out_old_r;

  // thread table and queue pointers
  logic [THREADS-1:0] slot_used_r;
  logic [THREADS-1:0] slot_ready_r;
  prio_t              slot_prio_r [THREADS];
  code_t              slot_next_r [THREADS];
  code_t              q_head_r [LEVELS];
  code_t              q_tail_r [LEVELS];

  logic    in_xfer;
  logic    out_xfer;
  tix_t    in_tix;
  logic    in_slot_ok;
  prio_t   in_pclamp;
  tix_t    tix;
  tix_t    prio_raddr;
  prio_t   prio_rd;
  code_t   cmp_code;
  logic    is_link;
  tix_t    cmp_tix;
  lvl_t    prio_lvl;

  logic    prio_we;
  tix_t    prio_waddr;
  prio_t   prio_wdata;
  logic    next_we;
  tix_t    next_waddr;
  code_t   next_wdata;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_xfer             = in_chan.valid && in_chan.ready;
  assign out_xfer            = out_valid_r && out_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.thread_out   = out_tout_r;
  assign out_chan.old_priority = out_old_r;

  // request decode at the input
  assign in_tix     = tix_t'(in_chan.thread_id);
  assign in_slot_ok = (int'(in_chan.thread_id) < THREADS) && slot_used_r[in_tix];
  assign in_pclamp  = (int'(in_chan.priority_req[PRIO_W-1:0]) > TOP_PRIORITY) ?
                      PRIO_W'(TOP_PRIORITY) : prio_t'(in_chan.priority_req[PRIO_W-1:0]);

  assign tix = tix_t'(tid_r);

  // priority table read port
  assign prio_raddr = (state_r == S_ENQ_LVL) ? t_r : tix;
  assign prio_rd    = slot_prio_r[prio_raddr];
  assign prio_lvl   = lvl_t'(prio_rd);

  // shared link compare: is the selected code a live thread slot
  always_comb begin
    unique case (state_r)
      S_ENQ_TAIL: cmp_code = q_tail_r[lv_r];
      S_POP_HEAD: cmp_code = q_head_r[lv_r];
      S_POP_NEXT: cmp_code = slot_next_r[h_r];
      S_SCAN_LVL: cmp_code = q_head_r[scan_l_r];
      default:    cmp_code = NONE_CODE;
    endcase
  end
  assign is_link = (int'(cmp_code) < THREADS);
  assign cmp_tix = tix_t'(cmp_code);

  // write ports of the unreset tables
  always_comb begin
    prio_we    = 1'b0;
    prio_waddr = tix;
    prio_wdata = pclamp_r;
    next_we    = 1'b0;
    next_waddr = t_r;
    next_wdata = NONE_CODE;
    unique case (state_r)
      S_SCAN_FREE: begin
        prio_we    = !slot_used_r[scan_t_r];
        prio_waddr = scan_t_r;
      end
      S_CHANGE: begin
        prio_we = !slot_ready_r[tix] && !pneg_r;
      end
      S_ENQ_TAIL: begin
        next_we = 1'b1;
      end
      S_ENQ_LINK: begin
        next_we    = 1'b1;
        next_waddr = tl_r;
        next_wdata = CODE_W'(t_r);
      end
      S_POP_HEAD: begin
        next_we    = !is_link;
        next_waddr = tix;
      end
      S_POP_NEXT: begin
        next_we    = 1'b1;
        next_waddr = tix;
      end
      default: begin
        prio_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prio_we) slot_prio_r[prio_waddr] <= prio_wdata;
    if (next_we) slot_next_r[next_waddr] <= next_wdata;
  end

  // sequencer, queue pointers, slot flags and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      slot_used_r  <= '0;
      slot_ready_r <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        q_head_r[l] <= NONE_CODE;
        q_tail_r[l] <= NONE_CODE;
      end
    end else begin
      // the final step reloads the output register itself
      if (out_xfer && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            tid_r        <= in_chan.thread_id;
            pneg_r       <= in_chan.priority_req[PREQ_W-1];
            pclamp_r     <= in_pclamp;
            res_tout_r   <= in_chan.thread_id;
            res_old_r    <= '0;
            t_r          <= in_tix;
            scan_t_r     <= '0;
            scan_l_r     <= '0;
            unique case (in_chan.action)
              ACT_CREATE: begin
                if (in_chan.priority_req[PREQ_W-1]) begin
                  res_status_r <= ST_INVALID;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_SCAN_FREE;
                end
              end
              ACT_READY: begin
                if (!in_slot_ok) begin
                  res_status_r <= ST_INVALID;
                  state_r      <= S_DONE;
                end else if (slot_ready_r[in_tix]) begin
                  res_status_r <= ST_ALREADY;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_ENQ_LVL;
                end
              end
              ACT_UNREADY: begin
                if (!in_slot_ok) begin
                  res_status_r <= ST_INVALID;
                  state_r      <= S_DONE;
                end else if (!slot_ready_r[in_tix]) begin
                  res_status_r <= ST_ALREADY;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_POP_LVL;
                end
              end
              ACT_SCHEDULE: begin
                res_status_r <= ST_OK;
                state_r      <= S_SCAN_LVL;
              end
              ACT_CHANGE: begin
                if (!in_slot_ok) begin
                  res_status_r <= ST_INVALID;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_CHANGE;
                end
              end
              ACT_EXIT: begin
                state_r <= S_DONE;
                if (!in_slot_ok) begin
                  res_status_r <= ST_INVALID;
                end else begin
                  res_status_r         <= ST_OK;
                  slot_used_r[in_tix]  <= 1'b0;
                  slot_ready_r[in_tix] <= 1'b0;
                end
              end
              default: begin
                res_status_r <= ST_INVALID;
                state_r      <= S_DONE;
              end
            endcase
          end
        end

        // first free slot, one probe per cycle
        S_SCAN_FREE: begin
          if (!slot_used_r[scan_t_r]) begin
            slot_used_r[scan_t_r]  <= 1'b1;
            slot_ready_r[scan_t_r] <= 1'b0;
            t_r                    <= scan_t_r;
            res_tout_r             <= TID_W'(scan_t_r);
            state_r                <= S_ENQ_LVL;
          end else if (scan_t_r == TIX_W'(THREADS - 1)) begin
            res_status_r <= ST_INVALID;
            state_r      <= S_DONE;
          end else begin
            scan_t_r <= scan_t_r + TIX_W'(1);
          end
        end

        // append t_r to its level
        S_ENQ_LVL: begin
          lv_r    <= prio_lvl;
          state_r <= S_ENQ_TAIL;
        end

        S_ENQ_TAIL: begin
          if (is_link) begin
            tl_r    <= cmp_tix;
            state_r <= S_ENQ_LINK;
          end else begin
            q_head_r[lv_r]    <= CODE_W'(t_r);
            q_tail_r[lv_r]    <= CODE_W'(t_r);
            slot_ready_r[t_r] <= 1'b1;
            state_r           <= S_DONE;
          end
        end

        S_ENQ_LINK: begin
          q_tail_r[lv_r]    <= CODE_W'(t_r);
          slot_ready_r[t_r] <= 1'b1;
          state_r           <= S_DONE;
        end

        // drop the head of the named thread's level
        S_POP_LVL: begin
          lv_r    <= prio_lvl;
          state_r <= S_POP_HEAD;
        end

        S_POP_HEAD: begin
          if (is_link) begin
            h_r     <= cmp_tix;
            state_r <= S_POP_NEXT;
          end else begin
            q_head_r[lv_r]    <= NONE_CODE;
            q_tail_r[lv_r]    <= NONE_CODE;
            slot_ready_r[tix] <= 1'b0;
            state_r           <= S_DONE;
          end
        end

        S_POP_NEXT: begin
          if (is_link) begin
            q_head_r[lv_r] <= cmp_code;
          end else begin
            q_head_r[lv_r] <= NONE_CODE;
            q_tail_r[lv_r] <= NONE_CODE;
          end
          slot_ready_r[tix] <= 1'b0;
          state_r           <= S_DONE;
        end

        // lowest non-empty level, one probe per cycle
        S_SCAN_LVL: begin
          if (is_link) begin
            res_tout_r <= TID_W'(cmp_code);
            state_r    <= S_DONE;
          end else if (scan_l_r == LVL_W'(LEVELS - 1)) begin
            res_status_r <= ST_NO_READY;
            state_r      <= S_DONE;
          end else begin
            scan_l_r <= scan_l_r + LVL_W'(1);
          end
        end

        // priority change, then append; refused while the thread is ready
        S_CHANGE: begin
          res_old_r <= prio_rd;
          if (slot_ready_r[tix]) begin
            res_status_r <= ST_ALREADY;
            state_r      <= S_DONE;
          end else begin
            t_r     <= tix;
            state_r <= S_ENQ_LVL;
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_tout_r   <= res_tout_r;
            out_old_r    <= res_old_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  logic [LEVELS-1:0] head_live;
  logic [LEVELS-1:0] tail_live;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_live[l] = (int'(q_head_r[l]) < THREADS);
      tail_live[l] = (int'(q_tail_r[l]) < THREADS);
    end
  end

  a_ready_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_ready_r & ~slot_used_r) == '0)
    else $error("ready flag set on a free slot");

  a_head_tail_agree: assert property (@(posedge clk) disable iff (!rst_n)
    head_live == tail_live)
    else $error("queue head and tail disagree on emptiness");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("new request taken while one is in flight");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_chan.ready)) |=>
      (out_valid_r && out_status_r == $past(res_status_r)))
    else $error("result not loaded on completion");

endmodule

// File: dv/priority_ready_queue_scheduler_unit_test.sv
// testbench for the ready-queue scheduler: directed and random requests checked against a shadow thread table
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_unit_test;
  import prqs_pkg::*;

  // action codes the block has no meaning for
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 880;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [TID_W-1:0]    thread_id;
    logic [PREQ_W-1:0]   priority_req;
  } request_t;

  typedef struct {
    status_t           status;
    logic [TID_W-1:0]  thread_out;
    prio_t             old_priority;
  } response_t;

  logic clk;
  logic rst_n;

  prqs_in_if  req_if ();
  prqs_out_if rsp_if ();

  priority_ready_queue_scheduler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  // shadow thread table and ready queues
  bit    used_tbl  [THREADS];
  bit    ready_tbl [THREADS];
  prio_t prio_tbl  [THREADS];
  code_t link_tbl  [THREADS];
  code_t head_tbl  [LEVELS];
  code_t tail_tbl  [LEVELS];

  request_t  request_queue[$];
  response_t pending_responses[$];

  bit          failed;
  bit          req_taken;
  int unsigned cyc;
  int unsigned idle_cycles;
  int unsigned src_gap;
  int unsigned sink_stall;

  // queue level a thread sits on
  function automatic int unsigned level_for(int unsigned t);
    int unsigned p;
    p = prio_tbl[t];
    return (p < LEVELS) ? p : LEVELS - 1;
  endfunction

  function automatic prio_t saturate_prio(prio_t p);
    return (p > TOP_PRIORITY) ? prio_t'(TOP_PRIORITY) : p;
  endfunction

  // append a thread to the tail of its level and mark it ready
  function automatic void link_at_tail(int unsigned t);
    int unsigned lv;
    int unsigned tl;
    lv = level_for(t);
    tl = tail_tbl[lv];
    link_tbl[t] = NONE_CODE;
    if (tl < THREADS) link_tbl[tl] = code_t'(t);
    else head_tbl[lv] = code_t'(t);
    tail_tbl[lv] = code_t'(t);
    ready_tbl[t] = 1'b1;
  endfunction

  // apply one request to the shadow table and return the response it yields
  function automatic response_t step_scheduler(request_t rq);
    response_t   rsp;
    int unsigned tid;
    int unsigned free_slot;
    int unsigned lv;
    int unsigned hd;
    int unsigned nx;
    int unsigned i;
    bit          pneg;
    bit          ok_slot;
    bit          found;
    prio_t       pval;
    tid = rq.thread_id;
    pneg = rq.priority_req[PREQ_W-1];
    pval = rq.priority_req[PRIO_W-1:0];
    rsp.status = ST_OK;
    rsp.thread_out = rq.thread_id;
    rsp.old_priority = '0;
    ok_slot = (tid < THREADS) ? used_tbl[tid] : 1'b0;
    case (rq.action)
      ACT_CREATE: begin
        free_slot = NONE_CODE;
        for (i = 0; i < THREADS; i++) begin
          if (!used_tbl[i]) begin
            free_slot = i;
            break;
          end
        end
        if (pneg || free_slot >= THREADS) begin
          rsp.status = ST_INVALID;
        end else begin
          used_tbl[free_slot] = 1'b1;
          ready_tbl[free_slot] = 1'b0;
          prio_tbl[free_slot] = saturate_prio(pval);
          link_at_tail(free_slot);
          rsp.thread_out = free_slot[TID_W-1:0];
        end
      end
      ACT_READY: begin
        if (!ok_slot) rsp.status = ST_INVALID;
        else if (ready_tbl[tid]) rsp.status = ST_ALREADY;
        else link_at_tail(tid);
      end
      ACT_UNREADY: begin
        if (!ok_slot) begin
          rsp.status = ST_INVALID;
        end else if (!ready_tbl[tid]) begin
          rsp.status = ST_ALREADY;
        end else begin
          // the head of the level leaves, whichever thread was named
          lv = level_for(tid);
          hd = head_tbl[lv];
          nx = NONE_CODE;
          if (hd < THREADS) nx = link_tbl[hd];
          if (nx < THREADS) begin
            head_tbl[lv] = code_t'(nx);
          end else begin
            head_tbl[lv] = NONE_CODE;
            tail_tbl[lv] = NONE_CODE;
          end
          ready_tbl[tid] = 1'b0;
          link_tbl[tid] = NONE_CODE;
        end
      end
      ACT_SCHEDULE: begin
        found = 1'b0;
        for (i = 0; i < LEVELS; i++) begin
          if (head_tbl[i] < THREADS) begin
            rsp.thread_out = head_tbl[i][TID_W-1:0];
            found = 1'b1;
            break;
          end
        end
        if (!found) rsp.status = ST_NO_READY;
      end
      ACT_CHANGE: begin
        if (!ok_slot) begin
          rsp.status = ST_INVALID;
        end else begin
          rsp.old_priority = prio_tbl[tid];
          if (ready_tbl[tid]) begin
            rsp.status = ST_ALREADY;
          end else begin
            if (!pneg) prio_tbl[tid] = saturate_prio(pval);
            link_at_tail(tid);
          end
        end
      end
      ACT_EXIT: begin
        // a ready thread stays linked in its queue
        if (!ok_slot) begin
          rsp.status = ST_INVALID;
        end else begin
          used_tbl[tid] = 1'b0;
          ready_tbl[tid] = 1'b0;
        end
      end
      default: rsp.status = ST_INVALID;
    endcase
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // idle length for either side: mostly short, a few long, none in calm stretches
  function automatic int unsigned idle_length();
    int unsigned r;
    if ((cyc % 1000) < 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_request(logic [ACTION_W-1:0] act, logic [TID_W-1:0] tid,
                                       logic [PREQ_W-1:0] preq);
    request_t rq;
    rq.action = act;
    rq.thread_id = tid;
    rq.priority_req = preq;
    request_queue.push_back(rq);
  endfunction

  // priority mostly low so levels collide, sometimes full range, sometimes negative
  function automatic logic [PREQ_W-1:0] random_priority();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return PREQ_W'($urandom_range(0, 3));
    if (r < 8) return PREQ_W'($urandom_range(0, 15));
    return PREQ_W'($urandom_range(16, 31));
  endfunction

  function automatic logic [ACTION_W-1:0] random_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return ACT_CREATE;
    if (r < 33) return ACT_READY;
    if (r < 48) return ACT_UNREADY;
    if (r < 66) return ACT_SCHEDULE;
    if (r < 81) return ACT_CHANGE;
    if (r < 93) return ACT_EXIT;
    return $urandom_range(0, 1) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    request_t rq;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        req_if.valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        rq = request_queue.pop_front();
        req_if.action <= rq.action;
        req_if.thread_id <= rq.thread_id;
        req_if.priority_req <= rq.priority_req;
        req_if.valid <= 1'b1;
        src_gap <= idle_length();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall <= idle_length();
    end
  end

  // transfer monitor, prediction and watchdog
  always @(posedge clk) begin
    request_t  rq;
    response_t exp_rsp;
    bit        rsp_taken;
    cyc <= cyc + 1;
    rsp_taken = rst_n && rsp_if.valid && rsp_if.ready;
    req_taken = rst_n && req_if.valid && req_if.ready;
    if (rsp_taken) begin
      if (pending_responses.size() == 0) begin
        $error("result transfer with no request outstanding: status %0d thread_out %0d",
               rsp_if.status, rsp_if.thread_out);
        failed = 1'b1;
      end else begin
        exp_rsp = pending_responses.pop_front();
        check_field("status", exp_rsp.status, rsp_if.status);
        check_field("thread_out", exp_rsp.thread_out, rsp_if.thread_out);
        check_field("old_priority", exp_rsp.old_priority, rsp_if.old_priority);
      end
    end
    if (req_taken) begin
      rq.action = req_if.action;
      rq.thread_id = req_if.thread_id;
      rq.priority_req = req_if.priority_req;
      pending_responses.push_back(step_scheduler(rq));
    end
    if (rsp_taken || req_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL priority_ready_queue_scheduler_unit");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int i;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_SCHEDULE;
    req_if.thread_id = '0;
    req_if.priority_req = '0;
    rsp_if.ready = 1'b0;
    failed = 1'b0;
    req_taken = 1'b0;
    cyc = 0;
    idle_cycles = 0;
    src_gap = 0;
    sink_stall = 0;
    for (i = 0; i < THREADS; i++) begin
      used_tbl[i] = 1'b0;
      ready_tbl[i] = 1'b0;
      prio_tbl[i] = '0;
      link_tbl[i] = NONE_CODE;
    end
    for (i = 0; i < LEVELS; i++) begin
      head_tbl[i] = NONE_CODE;
      tail_tbl[i] = NONE_CODE;
    end

    // directed: empty table, creation, queue order and each odd case
    push_request(ACT_SCHEDULE, 3'd5, 5'd0);   // no ready thread
    push_request(ACT_READY,    3'd0, 5'd0);   // slot not in use
    push_request(ACT_CREATE,   3'd7, 5'h1F);  // negative create priority
    push_request(ACT_CREATE,   3'd0, 5'd15);  // slot 0, lowest urgency
    push_request(ACT_CREATE,   3'd0, 5'd0);   // slot 1, most urgent
    push_request(ACT_CREATE,   3'd0, 5'd7);   // slot 2
    push_request(ACT_CREATE,   3'd0, 5'd7);   // slot 3 behind slot 2
    push_request(ACT_SCHEDULE, 3'd0, 5'd0);
    push_request(ACT_READY,    3'd2, 5'd0);   // already ready
    push_request(ACT_UNREADY,  3'd3, 5'd0);   // non-head: head of level 7 leaves
    push_request(ACT_UNREADY,  3'd3, 5'd0);   // not ready any more
    push_request(ACT_CHANGE,   3'd2, 5'd3);   // ready thread refuses change
    push_request(ACT_CHANGE,   3'd3, 5'h10);  // negative keeps old priority
    push_request(ACT_EXIT,     3'd0, 5'd0);   // exit while still queued
    push_request(ACT_EXIT,     3'd6, 5'd0);   // exit of a free slot
    push_request(ACT_UNDEF_LO, 3'd1, 5'd9);
    push_request(ACT_UNDEF_HI, 3'd7, 5'h0F);
    push_request(ACT_UNREADY,  3'd1, 5'd0);
    push_request(ACT_SCHEDULE, 3'd4, 5'd0);
    for (i = 0; i < 5; i++) push_request(ACT_CREATE, 3'd7, 5'd15 - 5'(i));  // fill every free slot
    push_request(ACT_CHANGE,   3'd4, 5'd1);
    push_request(ACT_SCHEDULE, 3'd0, 5'h15);

    // random requests
    for (i = 0; i < RANDOM_REQUESTS; i++)
      push_request(random_action(), TID_W'($urandom_range(0, 7)), random_priority());

    // reset held from the start, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || req_if.valid || pending_responses.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && pending_responses.size() == 0)
      $display("PASS priority_ready_queue_scheduler_unit");
    else
      $display("FAIL priority_ready_queue_scheduler_unit");
    $finish;
  end

endmodule

// File: filelist.f
hdl/prqs_pkg.sv
hdl/prqs_in_if.sv
hdl/prqs_out_if.sv
hdl/priority_ready_queue_scheduler_unit.sv
dv/priority_ready_queue_scheduler_unit_test.sv
